@@ sv/scv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scv_pkg
// Shared widths, the S-curve table and its lookup functions.
// ----------------------------------------------------------------------------
package scv_pkg;

   localparam int TABLE_POINTS = 200;          // saturation point of a segment index
   localparam int ROM_SEGMENTS = 200;          // segments in the stored curve
   localparam int HALF_POINTS  = 101;          // stored half curve, entries 0..100
   localparam int ONE_Q16      = 65536;

   localparam int POS_W   = 24;                // positions and floor offset
   localparam int TPP_W   = 8;                 // ticks per point
   localparam int TICK_W  = 8;
   localparam int IDX_W   = $clog2(TABLE_POINTS + 2);
   localparam int ENTRY_W = 17;                // unsigned Q1.16, up to 1.0
   localparam int DIFF_W  = ENTRY_W + 1;
   localparam int DELTA_W = POS_W + 1;         // target minus floor
   localparam int V_W     = 26;                // interpolated curve value times n
   localparam int PROD_W  = DELTA_W + V_W;
   localparam int DIV_W   = PROD_W - 16;       // magnitude after the Q16 shift
   localparam int SUM_W   = DIV_W + 2;

   localparam int CSR_IDX_W  = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_TPP       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_TPP     = 2'd2;

   localparam logic [1:0] DIR_IDLE = 2'd0;
   localparam logic [1:0] DIR_RISE = 2'd1;
   localparam logic [1:0] DIR_FALL = 2'd2;
   localparam logic [1:0] DIR_HOLD = 2'd3;

   localparam logic [15:0] HALF_CURVE [HALF_POINTS] = '{
      16'd0,     16'd4,     16'd16,    16'd36,    16'd65,
      16'd101,   16'd145,   16'd198,   16'd258,   16'd327,
      16'd403,   16'd488,   16'd580,   16'd681,   16'd789,
      16'd905,   16'd1029,  16'd1161,  16'd1301,  16'd1449,
      16'd1604,  16'd1767,  16'd1937,  16'd2115,  16'd2301,
      16'd2494,  16'd2695,  16'd2903,  16'd3119,  16'd3341,
      16'd3572,  16'd3809,  16'd4053,  16'd4305,  16'd4563,
      16'd4829,  16'd5101,  16'd5380,  16'd5666,  16'd5959,
      16'd6258,  16'd6564,  16'd6876,  16'd7195,  16'd7520,
      16'd7851,  16'd8188,  16'd8531,  16'd8881,  16'd9237,
      16'd9598,  16'd9964,  16'd10337, 16'd10714, 16'd11098,
      16'd11487, 16'd11881, 16'd12280, 16'd12684, 16'd13093,
      16'd13508, 16'd13926, 16'd14350, 16'd14778, 16'd15210,
      16'd15647, 16'd16088, 16'd16533, 16'd16982, 16'd17435,
      16'd17891, 16'd18352, 16'd18816, 16'd19283, 16'd19755,
      16'd20228, 16'd20705, 16'd21185, 16'd21668, 16'd22154,
      16'd22642, 16'd23133, 16'd23626, 16'd24121, 16'd24619,
      16'd25119, 16'd25620, 16'd26123, 16'd26628, 16'd27135,
      16'd27642, 16'd28151, 16'd28661, 16'd29172, 16'd29685,
      16'd30197, 16'd30710, 16'd31225, 16'd31738, 16'd32254,
      16'd32768
   };

   typedef struct packed {
      logic              rise;     // rise beat accepted
      logic              fall;     // fall beat accepted
      logic [TPP_W-1:0]  n;        // ticks per point in use, never zero
   } scv_cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]  rise_index;
      logic [TICK_W-1:0] rise_tick;
      logic [IDX_W-1:0]  fall_index;
      logic [TICK_W-1:0] fall_tick;
   } scv_ctr_type;

   function automatic logic [ENTRY_W-1:0] rise_entry_int(input int k);
      logic [ENTRY_W-1:0] e;
      if (k >= ROM_SEGMENTS) begin
         e = ENTRY_W'(ONE_Q16);
      end else if (k < HALF_POINTS) begin
         e = {1'b0, HALF_CURVE[k]};
      end else begin
         e = ENTRY_W'(ONE_Q16) - {1'b0, HALF_CURVE[ROM_SEGMENTS - k]};
      end
      return e;
   endfunction

   // curve entry at index i; falling curve mirrors the rising one
   function automatic logic [ENTRY_W-1:0] curve_entry(input logic rising,
                                                      input logic [IDX_W:0] i);
      int k;
      logic [ENTRY_W-1:0] e;
      k = int'(i);
      if (rising) begin
         e = rise_entry_int(k);
      end else if (k >= ROM_SEGMENTS) begin
         e = '0;
      end else begin
         e = rise_entry_int(ROM_SEGMENTS - k);
      end
      return e;
   endfunction

endpackage

@@ sv/scv_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scv_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scv_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [scv_pkg::DIV_W-1:0]  dividend,
   input  logic [scv_pkg::TPP_W-1:0]  divisor,
   output logic                       busy,
   output logic                       done,
   output logic [scv_pkg::DIV_W-1:0]  quotient
);
   import scv_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [TPP_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [TPP_W-1:0] dsr_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [TPP_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? TPP_W'(trial - {1'b0, dsr_ff}) : TPP_W'(trial);
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/scv_counters.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scv_counters
// Segment index and tick counters for the rising and falling profiles.
// ----------------------------------------------------------------------------
module scv_counters (
   input  logic                 clock,
   input  logic                 reset,
   input  scv_pkg::scv_cmd_type cmd,
   output scv_pkg::scv_ctr_type status
);
   import scv_pkg::*;

   scv_ctr_type ctr_ff, ctr_in;

   // one tick step; index moves on when the tick passes n
   function automatic logic [IDX_W+TICK_W-1:0] step(input logic [IDX_W-1:0] idx,
                                                   input logic [TICK_W-1:0] tick,
                                                   input logic [TPP_W-1:0] n);
      logic [TICK_W:0]  t;
      logic [IDX_W:0]   i;
      logic [TICK_W-1:0] t_out;
      t = {1'b0, tick} + 1'b1;
      i = {1'b0, idx};
      t_out = TICK_W'(t);
      if (t > {1'b0, n}) begin
         t_out = '0;
         i = i + 1'b1;
      end
      if (i > (IDX_W+1)'(TABLE_POINTS)) begin
         i = (IDX_W+1)'(TABLE_POINTS);
      end
      return {IDX_W'(i), t_out};
   endfunction

   always_comb begin
      ctr_in = ctr_ff;
      if (cmd.rise) begin
         {ctr_in.rise_index, ctr_in.rise_tick} =
            step(ctr_ff.rise_index, ctr_ff.rise_tick, cmd.n);
         ctr_in.fall_index = '0;
         ctr_in.fall_tick  = '0;
      end else if (cmd.fall) begin
         {ctr_in.fall_index, ctr_in.fall_tick} =
            step(ctr_ff.fall_index, ctr_ff.fall_tick, cmd.n);
         ctr_in.rise_index = '0;
         ctr_in.rise_tick  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
      end else begin
         ctr_ff <= ctr_in;
      end
   end

   assign status = ctr_ff;

endmodule

@@ sv/s_curve_setpoint_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s_curve_setpoint_generator
// S-curve position setpoint generator with a shared iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one tick beat: a direction and a target position. Rise and
//   fall beats produce one setpoint beat on rsp_*; idle and hold beats are
//   taken without leaving idle, produce nothing and leave the counters alone.
//   setpoint = floor + (target - floor) * s, with s interpolated linearly
//   between two adjacent entries of a Q1.16 S-curve table, truncated toward
//   zero and saturated to 24 bits.
//   A rise or fall beat passes from acceptance to rsp_valid through lookup,
//   two interpolation steps, multiply, magnitude, divider start, the divider
//   iterations, done seen and output load. req_ready is low for that whole
//   time, so a new beat is taken only after the last result is loaded.
//   The result sits in an output register; if rsp_ready is held low, the
//   next beat can be taken and computed, and finishes once the earlier
//   result has been taken.
//   csr_* writes floor offset, up and down ticks per point; the user must write
//   only while idle, the block does not enforce it. Reset (synchronous)
//   restores floor -100, 4 and 8 ticks per point, clears all profile counters.
// ----------------------------------------------------------------------------
module s_curve_setpoint_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_direction,
   input  logic signed [scv_pkg::POS_W-1:0] req_target_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [scv_pkg::POS_W-1:0] rsp_setpoint,
   input  logic                          csr_write_enable,
   input  logic [scv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [scv_pkg::POS_W-1:0]     csr_write_data
);
   import scv_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOK, ST_SCALE, ST_INTERP, ST_MUL, ST_ABS, ST_DIV, ST_FIN
   } state_type;

   state_type state_ff;

   // configuration
   logic signed [POS_W-1:0] floor_ff;
   logic [TPP_W-1:0]        up_tpp_ff;
   logic [TPP_W-1:0]        down_tpp_ff;

   // per-beat working registers
   logic                     rising_ff;
   logic signed [POS_W-1:0]  target_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [TICK_W-1:0]        tick_ff;
   logic [TPP_W-1:0]         n_ff;
   logic [ENTRY_W-1:0]       y0_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [DELTA_W-1:0] delta_ff;
   logic [ENTRY_W+TPP_W-1:0] base_ff;
   logic signed [V_W-1:0]    v_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     neg_ff;
   logic [DIV_W-1:0]         mag_ff;
   logic                     div_start_ff;

   logic                     rsp_valid_ff;
   logic signed [POS_W-1:0]  rsp_setpoint_ff;

   logic                     accept;
   logic                     active_dir;
   logic [TPP_W-1:0]         n_sel;
   scv_cmd_type              ctr_cmd;
   scv_ctr_type              ctr_status;

   logic                     div_busy;
   logic                     div_done;
   logic [DIV_W-1:0]         div_quotient;

   logic [ENTRY_W-1:0]       y0_w;
   logic [ENTRY_W-1:0]       y1_w;
   logic signed [V_W:0]      v_w;
   logic [PROD_W-1:0]        prod_abs;
   logic signed [SUM_W-1:0]  y_w;
   logic signed [SUM_W-1:0]  sum_w;
   logic signed [POS_W-1:0]  sat_w;
   logic                     out_free;
   logic                     fin_fire;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign active_dir = (req_direction == DIR_RISE) || (req_direction == DIR_FALL);

   // zero ticks per point acts as one
   always_comb begin
      n_sel = (req_direction == DIR_RISE) ? up_tpp_ff : down_tpp_ff;
      if (n_sel == '0) begin
         n_sel = TPP_W'(1);
      end
   end

   assign ctr_cmd.rise = accept && (req_direction == DIR_RISE);
   assign ctr_cmd.fall = accept && (req_direction == DIR_FALL);
   assign ctr_cmd.n    = n_sel;

   scv_counters u_counters (
      .clock  (clock),
      .reset  (reset),
      .cmd    (ctr_cmd),
      .status (ctr_status)
   );

   scv_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (mag_ff),
      .divisor  (n_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // table lookup at the segment and the one after it
   assign y0_w = curve_entry(rising_ff, {1'b0, idx_ff});
   assign y1_w = curve_entry(rising_ff, {1'b0, idx_ff} + 1'b1);

   // v = y0 * n + (y1 - y0) * tick; a stale tick above n is allowed
   assign v_w = $signed({2'b0, base_ff}) + diff_ff * $signed({1'b0, tick_ff});

   assign prod_abs = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);

   // quotient back to signed, add floor, clamp to 24 bits
   assign y_w   = neg_ff ? -$signed({2'b0, div_quotient}) : $signed({2'b0, div_quotient});
   assign sum_w = y_w + SUM_W'(floor_ff);
   always_comb begin
      if (sum_w > SUM_W'(signed'({1'b0, {(POS_W-1){1'b1}}}))) begin
         sat_w = {1'b0, {(POS_W-1){1'b1}}};
      end else if (sum_w < SUM_W'(signed'({1'b1, {(POS_W-1){1'b0}}}))) begin
         sat_w = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         sat_w = POS_W'(sum_w);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fin_fire = (state_ff == ST_FIN) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         floor_ff     <= -POS_W'(100);
         up_tpp_ff    <= TPP_W'(4);
         down_tpp_ff  <= TPP_W'(8);
      end else begin
         div_start_ff <= (state_ff == ST_ABS);
         if (fin_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FLOOR_OFFSET: floor_ff    <= csr_write_data;
               CSR_UP_TPP:       up_tpp_ff   <= csr_write_data[TPP_W-1:0];
               CSR_DOWN_TPP:     down_tpp_ff <= csr_write_data[TPP_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && active_dir) begin
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK:   state_ff <= ST_SCALE;
            ST_SCALE:  state_ff <= ST_INTERP;
            ST_INTERP: state_ff <= ST_MUL;
            ST_MUL:    state_ff <= ST_ABS;
            ST_ABS:    state_ff <= ST_DIV;
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_setpoint_ff <= sat_w;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end

      // datapath, no reset needed
      if (accept) begin
         rising_ff <= (req_direction == DIR_RISE);
         target_ff <= req_target_position;
         idx_ff    <= (req_direction == DIR_RISE) ? ctr_status.rise_index
                                                  : ctr_status.fall_index;
         tick_ff   <= (req_direction == DIR_RISE) ? ctr_status.rise_tick
                                                  : ctr_status.fall_tick;
         n_ff      <= n_sel;
      end
      if (state_ff == ST_LOOK) begin
         y0_ff    <= y0_w;
         diff_ff  <= $signed({1'b0, y1_w}) - $signed({1'b0, y0_w});
         delta_ff <= DELTA_W'(target_ff) - DELTA_W'(floor_ff);
      end
      if (state_ff == ST_SCALE) begin
         base_ff <= y0_ff * n_ff;
      end
      if (state_ff == ST_INTERP) begin
         v_ff <= V_W'(v_w);
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(delta_ff) * PROD_W'(v_ff);
      end
      if (state_ff == ST_ABS) begin
         neg_ff <= prod_ff[PROD_W-1];
         mag_ff <= prod_abs[PROD_W-1:16];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_setpoint = rsp_setpoint_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == ST_DIV))
      else $error("divider running outside the divide step");

   a_fall_clears_rise: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_direction == DIR_FALL)) |=>
         (ctr_status.rise_index == '0) && (ctr_status.rise_tick == '0))
      else $error("fall beat did not clear rise counters");

   a_index_saturates: assert property (@(posedge clock) disable iff (reset)
      (ctr_status.rise_index <= IDX_W'(TABLE_POINTS)) &&
      (ctr_status.fall_index <= IDX_W'(TABLE_POINTS)))
      else $error("segment index past table end");

   a_quiet_beat_no_work: assert property (@(posedge clock) disable iff (reset)
      (accept && !active_dir) |=> (state_ff == ST_IDLE) && $stable(ctr_status))
      else $error("idle or hold beat changed state");

endmodule
